// ----- rtl/fctf_pkg.sv -----
// Package for the fuzz clip tone filter: sequencer states, register indexes,
// configuration struct and fixed-point constants. No dependencies.
`default_nettype none

package fctf_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BYPASS        = 3'd0,
        CFG_DRIVE_GAIN    = 3'd1,
        CFG_TONE_MIX      = 3'd2,
        CFG_VOLUME_GAIN   = 3'd3,
        CFG_LOWPASS_COEFF = 3'd4
    } cfg_index_t;

    // Reset values of the registers
    localparam logic [15:0] DRIVE_RESET  = 16'd24576;
    localparam logic [16:0] TONE_RESET   = 17'd32768;
    localparam logic [16:0] VOLUME_RESET = 17'd32768;

    // Fixed-point constants
    localparam int          DRIVE_FRAC = 12;
    localparam int          COEF_FRAC  = 16;
    localparam int          VOL_FRAC   = 15;
    localparam logic [15:0] SHAPE_K    = 16'd19661;   // 0.3 in Q0.16
    localparam logic [16:0] UNIT16     = 17'h10000;   // 1.0 in Q1.16

    // Register file contents as seen by the datapath (tone and volume saturated)
    typedef struct packed {
        logic        bypass;
        logic [15:0] drive_gain;
        logic [16:0] tone_mix;
        logic [16:0] volume_gain;
        logic [15:0] lowpass_coeff;
    } cfg_t;

    // Sequencer: each product has an issue state and a state that takes the result
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DRIVE,
        ST_CLIP,
        ST_KMUL,
        ST_KRES,
        ST_SHAPE,
        ST_SRES,
        ST_ST1,
        ST_ST1R,
        ST_ST2,
        ST_ST2R,
        ST_MIXC,
        ST_MIXCR,
        ST_MIXF,
        ST_MIXFR,
        ST_VOL,
        ST_VOLR,
        ST_OUT
    } seq_state_t;

endpackage

`default_nettype wire

// ----- rtl/fctf_if.sv -----
// Channel interfaces of the fuzz clip tone filter: sample in, sample out and
// configuration write. Depends on fctf_pkg for the configuration port widths.
`default_nettype none

interface fctf_in_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_in;
    logic                last_in_frame;

    modport source (output valid, output sample_in, output last_in_frame, input ready);
    modport sink   (input valid, input sample_in, input last_in_frame, output ready);
endinterface

interface fctf_out_if #(parameter int W = 24);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_out;
    logic                last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

interface fctf_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fctf_pkg::CFG_INDEX_W-1:0]   index;
    logic [fctf_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/fctf_cfg.sv -----
// Configuration register file of the fuzz clip tone filter.
// Depends on fctf_pkg (register indexes, reset values, cfg_t).
`default_nettype none

module fctf_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_valid,
    output logic                                  wr_ready,
    input  wire logic [fctf_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [fctf_pkg::CFG_DATA_W-1:0]  wr_data,
    output fctf_pkg::cfg_t                        cfg
);

    logic        bypass_reg;
    logic [15:0] drive_reg;
    logic [16:0] tone_reg;
    logic [16:0] volume_reg;
    logic [15:0] coeff_reg;

    assign wr_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
            drive_reg  <= fctf_pkg::DRIVE_RESET;
            tone_reg   <= fctf_pkg::TONE_RESET;
            volume_reg <= fctf_pkg::VOLUME_RESET;
            coeff_reg  <= '0;
        end
        else if (wr_valid)
        begin
            unique case (wr_index)
                fctf_pkg::CFG_BYPASS:        bypass_reg <= wr_data[0];
                fctf_pkg::CFG_DRIVE_GAIN:    drive_reg  <= wr_data[15:0];
                fctf_pkg::CFG_TONE_MIX:      tone_reg   <= wr_data;
                fctf_pkg::CFG_VOLUME_GAIN:   volume_reg <= wr_data;
                fctf_pkg::CFG_LOWPASS_COEFF: coeff_reg  <= wr_data[15:0];
                default:                     ;  // drop writes beyond the list
            endcase
        end
    end

    // Saturate tone and volume to 1.0 and 2.0
    always_comb
    begin
        cfg.bypass        = bypass_reg;
        cfg.drive_gain    = drive_reg;
        cfg.tone_mix      = (tone_reg > fctf_pkg::UNIT16) ? fctf_pkg::UNIT16 : tone_reg;
        cfg.volume_gain   = (volume_reg > fctf_pkg::UNIT16) ? fctf_pkg::UNIT16 : volume_reg;
        cfg.lowpass_coeff = coeff_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/fctf_mul.sv -----
// Shared signed multiplier with a registered product.
// No package dependency.
`default_nettype none

module fctf_mul #(
    parameter int A_W = 25,
    parameter int B_W = 25
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [A_W-1:0]   a,
    input  wire logic signed [B_W-1:0]   b,
    output logic signed [A_W+B_W-1:0]    prod_reg
);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fctf_seq.sv -----
// Sequencer and datapath registers of the fuzz clip tone filter: drives the
// shared multiplier, post-processes each product, holds filter state and the
// output register. Depends on fctf_pkg (states, cfg_t, constants).
`default_nettype none

module fctf_seq #(
    parameter int W     = 24,
    parameter int OPA_W = W + 1,
    parameter int OPB_W = (W + 1 > 18) ? W + 1 : 18,
    parameter int PW    = OPA_W + OPB_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire fctf_pkg::cfg_t        cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [W-1:0]   in_sample,
    input  wire logic                  in_last,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [W-1:0]        out_sample,
    output logic                       out_last,
    output logic                       mul_en,
    output logic signed [OPA_W-1:0]    mul_a,
    output logic signed [OPB_W-1:0]    mul_b,
    input  wire logic signed [PW-1:0]  mul_prod
);

    localparam logic signed [PW-1:0] ONE_P     = $signed(PW'(1) << (W - 1));
    localparam logic signed [PW-1:0] NEG_ONE_P = -ONE_P;
    localparam logic signed [PW-1:0] MAX_P     = ONE_P - PW'(1);
    localparam logic        [W-1:0]  ONE_W     = W'(1) << (W - 1);

    fctf_pkg::seq_state_t state_reg, state_next;

    logic signed [W-1:0] x_reg;
    logic signed [W:0]   p_reg;
    logic        [W-1:0] work_reg;      // |p| first, then 1 - k*|p|
    logic signed [W-1:0] c_reg;
    logic signed [W:0]   diff_reg;
    logic signed [W-1:0] s1_reg, s1_next;
    logic signed [W-1:0] s2_reg, s2_next;
    logic signed [PW-1:0] acc_reg;
    logic signed [W-1:0] m_reg;
    logic signed [W-1:0] res_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic signed [W-1:0] out_sample_reg;
    logic                out_last_reg;

    logic signed [PW-1:0] sh_drive, sh_coef, sh_shape, sh_vol, mix_sum, sh_mix;
    logic signed [W:0]    p_clip, p_abs;
    logic signed [W:0]    stage_in, stage_sum;
    logic signed [W-1:0]  stage_out;
    logic signed [W-1:0]  res_clamp;
    logic        [16:0]   tone_comp;
    logic                 out_free;

    assign in_ready   = (state_reg == fctf_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign out_last   = out_last_reg;
    assign out_free   = !out_valid_reg || out_ready;

    // Post-processing of the registered product
    always_comb
    begin
        sh_drive = mul_prod >>> fctf_pkg::DRIVE_FRAC;
        sh_coef  = mul_prod >>> fctf_pkg::COEF_FRAC;
        sh_shape = mul_prod >>> (W - 1);
        sh_vol   = mul_prod >>> fctf_pkg::VOL_FRAC;
        mix_sum  = acc_reg + mul_prod;
        sh_mix   = mix_sum >>> fctf_pkg::COEF_FRAC;

        if (sh_drive > ONE_P)
            p_clip = ONE_P[W:0];
        else if (sh_drive < NEG_ONE_P)
            p_clip = NEG_ONE_P[W:0];
        else
            p_clip = sh_drive[W:0];
        p_abs = p_clip[W] ? -p_clip : p_clip;

        stage_in  = (state_reg == fctf_pkg::ST_ST1R) ? (W+1)'(c_reg) : (W+1)'(s1_reg);
        stage_sum = stage_in + sh_coef[W:0];
        stage_out = stage_sum[W-1:0];

        if (sh_vol > MAX_P)
            res_clamp = MAX_P[W-1:0];
        else if (sh_vol < NEG_ONE_P)
            res_clamp = NEG_ONE_P[W-1:0];
        else
            res_clamp = sh_vol[W-1:0];

        tone_comp = fctf_pkg::UNIT16 - cfg.tone_mix;
    end

    // Next state and multiplier operands
    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = OPA_W'(x_reg);
        mul_b      = $signed(OPB_W'(cfg.drive_gain));
        s1_next    = s1_reg;
        s2_next    = s2_reg;
        unique case (state_reg) inside
            fctf_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = cfg.bypass ? fctf_pkg::ST_OUT : fctf_pkg::ST_DRIVE;
            end
            fctf_pkg::ST_DRIVE:
            begin
                mul_en     = 1'b1;
                state_next = fctf_pkg::ST_CLIP;
            end
            fctf_pkg::ST_CLIP:  state_next = fctf_pkg::ST_KMUL;
            fctf_pkg::ST_KMUL:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed(OPA_W'(work_reg));
                mul_b      = $signed(OPB_W'(fctf_pkg::SHAPE_K));
                state_next = fctf_pkg::ST_KRES;
            end
            fctf_pkg::ST_KRES:  state_next = fctf_pkg::ST_SHAPE;
            fctf_pkg::ST_SHAPE:
            begin
                mul_en     = 1'b1;
                mul_a      = p_reg;
                mul_b      = $signed(OPB_W'(work_reg));
                state_next = fctf_pkg::ST_SRES;
            end
            fctf_pkg::ST_SRES:  state_next = fctf_pkg::ST_ST1;
            fctf_pkg::ST_ST1,
            fctf_pkg::ST_ST2:
            begin
                mul_en     = 1'b1;
                mul_a      = diff_reg;
                mul_b      = $signed(OPB_W'(cfg.lowpass_coeff));
                state_next = (state_reg == fctf_pkg::ST_ST1) ? fctf_pkg::ST_ST1R
                                                             : fctf_pkg::ST_ST2R;
            end
            fctf_pkg::ST_ST1R:
            begin
                s1_next    = stage_out;
                state_next = fctf_pkg::ST_ST2;
            end
            fctf_pkg::ST_ST2R:
            begin
                s2_next    = stage_out;
                state_next = fctf_pkg::ST_MIXC;
            end
            fctf_pkg::ST_MIXC:
            begin
                mul_en     = 1'b1;
                mul_a      = OPA_W'(c_reg);
                mul_b      = $signed(OPB_W'(tone_comp));
                state_next = fctf_pkg::ST_MIXCR;
            end
            fctf_pkg::ST_MIXCR: state_next = fctf_pkg::ST_MIXF;
            fctf_pkg::ST_MIXF:
            begin
                mul_en     = 1'b1;
                mul_a      = OPA_W'(s2_reg);
                mul_b      = $signed(OPB_W'(cfg.tone_mix));
                state_next = fctf_pkg::ST_MIXFR;
            end
            fctf_pkg::ST_MIXFR: state_next = fctf_pkg::ST_VOL;
            fctf_pkg::ST_VOL:
            begin
                mul_en     = 1'b1;
                mul_a      = OPA_W'(m_reg);
                mul_b      = $signed(OPB_W'(cfg.volume_gain));
                state_next = fctf_pkg::ST_VOLR;
            end
            fctf_pkg::ST_VOLR:  state_next = fctf_pkg::ST_OUT;
            fctf_pkg::ST_OUT:
            begin
                if (out_free)
                    state_next = fctf_pkg::ST_IDLE;
            end
            default:            state_next = fctf_pkg::ST_IDLE;
        endcase
    end

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fctf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            s1_reg        <= '0;
            s2_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            s1_reg    <= s1_next;
            s2_reg    <= s2_next;
            if (state_reg == fctf_pkg::ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            fctf_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_reg    <= in_sample;
                    res_reg  <= in_sample;
                    last_reg <= in_last;
                end
            end
            fctf_pkg::ST_CLIP:
            begin
                p_reg    <= p_clip;
                work_reg <= p_abs[W-1:0];
            end
            fctf_pkg::ST_KRES:  work_reg <= ONE_W - sh_coef[W-1:0];
            fctf_pkg::ST_SRES:
            begin
                c_reg    <= sh_shape[W-1:0];
                diff_reg <= (W+1)'(s1_reg) - (W+1)'($signed(sh_shape[W-1:0]));
            end
            fctf_pkg::ST_ST1R:  diff_reg <= (W+1)'(s2_reg) - (W+1)'(stage_out);
            fctf_pkg::ST_MIXCR: acc_reg  <= mul_prod;
            fctf_pkg::ST_MIXFR: m_reg    <= sh_mix[W-1:0];
            fctf_pkg::ST_VOLR:  res_reg  <= res_clamp;
            fctf_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_sample_reg <= res_reg;
                    out_last_reg   <= last_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/fuzz_clip_tone_filter_core.sv -----
// Top level of the fuzz clip tone filter: configuration registers, sequencer
// and one shared multiplier. Depends on fctf_pkg, fctf_if, fctf_cfg, fctf_seq, fctf_mul.
//
//  channel   dir   handshake            payload
//  in_ch     in    valid / ready        sample_in (signed, SAMPLE_WIDTH), last_in_frame
//  out_ch    out   valid / ready        sample_out (signed, SAMPLE_WIDTH), last_out
//  cfg_ch    in    valid / ready (=1)   index (3 bits), data (17 bits)
//
// A processed item passes through eight dependent products on one multiplier, each
// with an issue state and a post-process state; then ST_OUT loads the output and
// ST_IDLE takes the next item. A bypass item goes from ST_IDLE straight to ST_OUT.
// A new item is taken only in ST_IDLE, never while the last one is still in work.
// Reset clears the sequencer, output valid, both filter stages and the configuration registers.
// A stalled output holds the sequencer in its last state and blocks new items.
`default_nettype none

module fuzz_clip_tone_filter_core #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fctf_in_if.sink     in_ch,
    fctf_out_if.source  out_ch,
    fctf_cfg_if.sink    cfg_ch
);

    // Multiplier operand widths: A holds a sample plus one bit (clipped value,
    // filter difference); B must also take the shaping factor (1 - k*|p|).
    localparam int OPA_W = SAMPLE_WIDTH + 1;
    localparam int OPB_W = (SAMPLE_WIDTH + 1 > 18) ? SAMPLE_WIDTH + 1 : 18;
    localparam int PW    = OPA_W + OPB_W;

    fctf_pkg::cfg_t          cfg;
    logic                    mul_en;
    logic signed [OPA_W-1:0] mul_a;
    logic signed [OPB_W-1:0] mul_b;
    logic signed [PW-1:0]    mul_prod;

    // Register file; tone and volume come out already saturated
    fctf_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (cfg_ch.valid),
        .wr_ready (cfg_ch.ready),
        .wr_index (cfg_ch.index),
        .wr_data  (cfg_ch.data),
        .cfg      (cfg)
    );

    // Sequencer: walks drive, clip, shape, two filter stages, mix and volume
    fctf_seq #(
        .W     (SAMPLE_WIDTH),
        .OPA_W (OPA_W),
        .OPB_W (OPB_W),
        .PW    (PW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_sample  (in_ch.sample_in),
        .in_last    (in_ch.last_in_frame),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_sample (out_ch.sample_out),
        .out_last   (out_ch.last_out),
        .mul_en     (mul_en),
        .mul_a      (mul_a),
        .mul_b      (mul_b),
        .mul_prod   (mul_prod)
    );

    // The one multiplier, product registered before any use
    fctf_mul #(
        .A_W (OPA_W),
        .B_W (OPB_W)
    ) u_mul (
        .clk      (clk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (mul_prod)
    );

`ifndef SYNTHESIS
    // Block goes busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> !in_ch.ready)
        else $error("input ready stayed high after an item was taken");

    // A processed item still keeps the block busy in the middle of the multiply chain
    a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && !cfg.bypass |=> ##8 !in_ch.ready)
        else $error("block took a new item in the middle of the multiply chain");

    // Bypass item reaches a free output unchanged
    a_bypass_pass: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready && cfg.bypass && !out_ch.valid |=> ##1
        (out_ch.valid && out_ch.sample_out == $past(in_ch.sample_in, 2)
         && out_ch.last_out == $past(in_ch.last_in_frame, 2)))
        else $error("bypass item did not pass through unchanged");
`endif

endmodule

`default_nettype wire
